// ----- rtl/core/distance_hand_state_qualifier_top_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef DISTANCE_HAND_STATE_QUALIFIER_TOP_ASSERT_SVH
`define DISTANCE_HAND_STATE_QUALIFIER_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define DHSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhsq assertion failed");

// Next-cycle implication, switched off while reset is held.
`define DHSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhsq assertion failed");

`endif

// ----- rtl/core/dhsq_pkg.sv -----
package dhsq_pkg;

    typedef enum logic [1:0] {
        HAND_NONE  = 2'd0,
        HAND_NEAR  = 2'd1,
        HAND_HOVER = 2'd2
    } t_hand;

    localparam int DEF_TIME_BITS = 32;
    localparam int DEF_DIST_BITS = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int STABLE_W   = 32;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_MODE   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_INVALID_CODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_ENTER     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_EXIT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_MIN      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_ENTER    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_EXIT     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_STABLE   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HAND_STABLE    = 8'd7;

    localparam logic [15:0] RST_INVALID_CODE = 16'd65535;
    localparam logic [15:0] RST_NEAR_ENTER   = 16'd100;
    localparam logic [15:0] RST_NEAR_EXIT    = 16'd120;
    localparam logic [15:0] RST_HOVER_MIN    = 16'd100;
    localparam logic [15:0] RST_HOVER_ENTER  = 16'd300;
    localparam logic [15:0] RST_HOVER_EXIT   = 16'd350;
    localparam logic [STABLE_W-1:0] RST_LEAVE_STABLE = 32'd200;
    localparam logic [STABLE_W-1:0] RST_HAND_STABLE  = 32'd100;

endpackage

// ----- rtl/core/distance_hand_state_qualifier_top.sv -----
// Hand-state qualifier for a distance sensor. Every beat on the input channel is either a
// distance sample or a mode-change event; samples taken in demo mode yield one result beat
// carrying the qualified state (no hand, near, hover), the sample, the time spent in the
// current state and a flag for a hand that has just left; a mode event entering demo mode
// yields a result beat too. A new state is only taken once it has persisted for
// hand_stable_ms (or leave_stable_ms towards no hand). The block takes one beat per clock
// cycle while no result is held by back-pressure: a beat waits in the input register, where
// the state update is done combinationally, and its result is loaded from there into the
// output register once that register is free. The state update loop sets that rate; beats
// that give no result pass even while the output register is held by back-pressure. The
// configuration port is always ready and is to be written only while the block is idle.
module distance_hand_state_qualifier_top
    import dhsq_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int DIST_BITS = DEF_DIST_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_req_type,
    input  logic [DIST_BITS-1:0]  i_distance_mm,
    input  logic                  i_distance_valid,
    input  logic [TIME_BITS-1:0]  i_now_ms,
    input  logic                  i_demo_active,
    input  logic                  i_prev_demo_active,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_hand_state,
    output logic [DIST_BITS-1:0]  o_report_distance,
    output logic                  o_report_valid,
    output logic [TIME_BITS-1:0]  o_stable_time_ms,
    output logic                  o_leave_detected,
    output logic [1:0]            o_left_state
);

    localparam int CMP_W = (TIME_BITS > STABLE_W) ? TIME_BITS : STABLE_W;

    // configuration
    logic [DIST_BITS-1:0] r_invalid_code, r_near_enter, r_near_exit;
    logic [DIST_BITS-1:0] r_hover_min, r_hover_enter, r_hover_exit;
    logic [STABLE_W-1:0]  r_leave_stable, r_hand_stable;

    // input register
    logic                 r_sv;
    logic                 r_req;
    logic [DIST_BITS-1:0] r_dist;
    logic                 r_dvalid;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_demo, r_prev_demo;

    // qualifier state
    t_hand                r_cur, n_cur;
    t_hand                r_cand, n_cand;
    logic [TIME_BITS-1:0] r_cand_since, n_cand_since;
    logic [TIME_BITS-1:0] r_state_since, n_state_since;

    // output register
    logic                 r_ov;
    t_hand                r_o_hand, n_o_hand;
    logic [DIST_BITS-1:0] r_o_dist, n_o_dist;
    logic                 r_o_valid, n_o_valid;
    logic [TIME_BITS-1:0] r_o_time, n_o_time;
    logic                 r_o_leave, n_o_leave;
    t_hand                r_o_left, n_o_left;

    logic                 s_res;
    logic                 s_fire;
    logic                 out_free;
    t_hand                desired;
    logic                 dist_ok;
    logic [TIME_BITS-1:0] cand_base;
    logic [TIME_BITS-1:0] cand_age;
    logic [STABLE_W-1:0]  need;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_code <= DIST_BITS'(RST_INVALID_CODE);
            r_near_enter   <= DIST_BITS'(RST_NEAR_ENTER);
            r_near_exit    <= DIST_BITS'(RST_NEAR_EXIT);
            r_hover_min    <= DIST_BITS'(RST_HOVER_MIN);
            r_hover_enter  <= DIST_BITS'(RST_HOVER_ENTER);
            r_hover_exit   <= DIST_BITS'(RST_HOVER_EXIT);
            r_leave_stable <= RST_LEAVE_STABLE;
            r_hand_stable  <= RST_HAND_STABLE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INVALID_CODE: r_invalid_code <= i_cfg_data[DIST_BITS-1:0];
                REG_NEAR_ENTER:   r_near_enter   <= i_cfg_data[DIST_BITS-1:0];
                REG_NEAR_EXIT:    r_near_exit    <= i_cfg_data[DIST_BITS-1:0];
                REG_HOVER_MIN:    r_hover_min    <= i_cfg_data[DIST_BITS-1:0];
                REG_HOVER_ENTER:  r_hover_enter  <= i_cfg_data[DIST_BITS-1:0];
                REG_HOVER_EXIT:   r_hover_exit   <= i_cfg_data[DIST_BITS-1:0];
                REG_LEAVE_STABLE: r_leave_stable <= i_cfg_data[STABLE_W-1:0];
                REG_HAND_STABLE:  r_hand_stable  <= i_cfg_data[STABLE_W-1:0];
                default: ;
            endcase
        end
    end

    // A beat without a result never waits for the output side.
    assign out_free   = !r_ov || i_out_ready;
    assign s_fire     = r_sv && (!s_res || out_free);
    assign o_in_ready = !r_sv || s_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (o_in_ready) begin
            r_sv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req       <= i_req_type;
            r_dist      <= i_distance_mm;
            r_dvalid    <= i_distance_valid;
            r_now       <= i_now_ms;
            r_demo      <= i_demo_active;
            r_prev_demo <= i_prev_demo_active;
        end
    end

    // Classification with hysteresis on the current qualified state.
    always_comb begin
        dist_ok = r_dvalid && (r_dist != r_invalid_code);
        desired = HAND_NONE;
        if (dist_ok) begin
            case (r_cur)
                HAND_NEAR: begin
                    if (r_dist > r_hover_exit) begin
                        desired = HAND_NONE;
                    end else if (r_dist > r_near_exit && r_dist <= r_hover_enter) begin
                        desired = HAND_HOVER;
                    end else begin
                        desired = HAND_NEAR;
                    end
                end
                HAND_HOVER: begin
                    if (r_dist > r_hover_exit) begin
                        desired = HAND_NONE;
                    end else if (r_dist < r_near_enter) begin
                        desired = HAND_NEAR;
                    end else begin
                        desired = HAND_HOVER;
                    end
                end
                default: begin
                    if (r_dist < r_near_enter) begin
                        desired = HAND_NEAR;
                    end else if (r_dist >= r_hover_min && r_dist <= r_hover_enter) begin
                        desired = HAND_HOVER;
                    end else begin
                        desired = HAND_NONE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_cur         = r_cur;
        n_cand        = r_cand;
        n_cand_since  = r_cand_since;
        n_state_since = r_state_since;
        s_res         = 1'b0;
        n_o_hand      = HAND_NONE;
        n_o_dist      = '0;
        n_o_valid     = 1'b0;
        n_o_time      = '0;
        n_o_leave     = 1'b0;
        n_o_left      = HAND_NONE;

        // A fresh candidate starts its timer at this sample.
        cand_base = (r_cand != desired) ? r_now : r_cand_since;
        cand_age  = r_now - cand_base;
        need      = (desired == HAND_NONE) ? r_leave_stable : r_hand_stable;

        if (r_req == REQ_MODE) begin
            if (!r_demo || !r_prev_demo) begin
                n_cur         = HAND_NONE;
                n_cand        = HAND_NONE;
                n_cand_since  = '0;
                n_state_since = r_now;
                // Entering demo mode reports the cleared state.
                s_res         = r_demo;
            end
        end else if (r_demo) begin
            s_res     = 1'b1;
            n_o_dist  = r_dist;
            n_o_valid = r_dvalid;
            if (desired != r_cur) begin
                n_cand       = desired;
                n_cand_since = cand_base;
                if (CMP_W'(cand_age) >= CMP_W'(need)) begin
                    n_cur         = desired;
                    n_state_since = r_now;
                    n_cand_since  = r_now;
                    if (desired == HAND_NONE) begin
                        n_o_leave = 1'b1;
                        n_o_left  = r_cur;
                    end
                end
            end else begin
                n_cand       = r_cur;
                n_cand_since = r_now;
            end
            n_o_hand = n_cur;
            n_o_time = r_now - n_state_since;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur         <= HAND_NONE;
            r_cand        <= HAND_NONE;
            r_cand_since  <= '0;
            r_state_since <= '0;
        end else if (s_fire) begin
            r_cur         <= n_cur;
            r_cand        <= n_cand;
            r_cand_since  <= n_cand_since;
            r_state_since <= n_state_since;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s_fire && s_res) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && s_res) begin
            r_o_hand  <= n_o_hand;
            r_o_dist  <= n_o_dist;
            r_o_valid <= n_o_valid;
            r_o_time  <= n_o_time;
            r_o_leave <= n_o_leave;
            r_o_left  <= n_o_left;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_hand_state      = r_o_hand;
    assign o_report_distance = r_o_dist;
    assign o_report_valid    = r_o_valid;
    assign o_stable_time_ms  = r_o_time;
    assign o_leave_detected  = r_o_leave;
    assign o_left_state      = r_o_left;

endmodule

// ----- rtl/core/dhsq_checker.sv -----
`include "distance_hand_state_qualifier_top_assert.svh"

module dhsq_assert_checker
    import dhsq_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int DIST_BITS = DEF_DIST_BITS
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           o_hand_state,
    input logic [DIST_BITS-1:0] o_report_distance,
    input logic                 o_report_valid,
    input logic [TIME_BITS-1:0] o_stable_time_ms,
    input logic                 o_leave_detected,
    input logic [1:0]           o_left_state
);

    // A stalled result beat keeps its contents.
    `DHSQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_hand_state) && $stable(o_report_distance) && $stable(o_report_valid) && $stable(o_stable_time_ms) && $stable(o_leave_detected) && $stable(o_left_state))

    // A leave lands in no hand and names the state that was present.
    `DHSQ_ASSERT_NOW(a_leave_state, i_clk, i_rst_n, o_out_valid && o_leave_detected, o_hand_state == HAND_NONE && (o_left_state == HAND_NEAR || o_left_state == HAND_HOVER))

    // The left state is only reported together with a leave.
    `DHSQ_ASSERT_NOW(a_left_quiet, i_clk, i_rst_n, o_out_valid && !o_leave_detected, o_left_state == HAND_NONE)

    // A state change restarts the time in state, so a leave always shows zero.
    `DHSQ_ASSERT_NOW(a_leave_time, i_clk, i_rst_n, o_out_valid && o_stable_time_ms != '0, !o_leave_detected)

endmodule

bind distance_hand_state_qualifier_top dhsq_assert_checker #(
    .TIME_BITS(TIME_BITS),
    .DIST_BITS(DIST_BITS)
) u_dhsq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_hand_state      (o_hand_state),
    .o_report_distance (o_report_distance),
    .o_report_valid    (o_report_valid),
    .o_stable_time_ms  (o_stable_time_ms),
    .o_leave_detected  (o_leave_detected),
    .o_left_state      (o_left_state)
);
